// ===== rtl/assert_macros.svh =====
// assertion macros, included by the top level chained_hash_key_table
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, off while reset is low
`define CHKT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be true
`define CHKT_NEVER(lbl, clk, rst_n, cond, msg) \
  `CHKT_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

// ===== rtl/chkt_pkg.sv =====
// shared types and constants of the chained hash key table
package chkt_pkg;

  localparam int NUM_BUCKETS_DEF  = 64;
  localparam int BUCKET_SLOTS_DEF = 4;
  localparam int KEY_BITS_DEF     = 16;

  // fixed field widths
  localparam int KEY_W    = 16;
  localparam int HANDLE_W = 16;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_DUPLICATE = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // result and write strobes of one bucket operation
  typedef struct packed {
    status_t             status;
    logic [HANDLE_W-1:0] found_handle;
    logic                vld_we;
    logic                ent_we;
  } slot_res_t;

endpackage

// ===== rtl/chained_hash_key_table.sv =====
// top level of the chained hash key table: pipeline, row forwarding, clear pass
//
// keyed table of NUM_BUCKETS buckets with BUCKET_SLOTS slots each; a key maps
// to bucket (key mod NUM_BUCKETS) and that bucket's slots are compared at once
// input beat: tuser carries op (lookup, insert, remove), tdata carries key
// and record handle; every input beat gives exactly one output beat
// output beat: tuser carries status, tdata the found handle (zero unless a
// lookup hits)
// path: a taken beat enters the input register, then moves through the hash
// multiply register, bucket row read and the result register on out_tvalid
// throughput: one beat per cycle while out_tready is high and no clear pass
// runs; a back-to-back beat to the same bucket sees the row written by the
// beat before it through a forwarding register
// reset: rst_n low clears all pipeline valids; after release a clear pass
// wipes the valid rows of all NUM_BUCKETS buckets, one bucket a cycle, with
// in_tready low; key and handle rows are not cleared
// stall: with out_tready low the result register holds, the stages fill up
// behind it and in_tready drops once the input register cannot move on
`include "assert_macros.svh"

module chained_hash_key_table #(
  parameter int NUM_BUCKETS  = chkt_pkg::NUM_BUCKETS_DEF,
  parameter int BUCKET_SLOTS = chkt_pkg::BUCKET_SLOTS_DEF,
  parameter int KEY_BITS     = chkt_pkg::KEY_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // key [15:0], record_handle [31:16]
  input  logic [1:0]  in_tuser,   // op [1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // found_handle [15:0]
  output logic [1:0]  out_tuser   // status [1:0]
);

  localparam int HW = chkt_pkg::HANDLE_W;
  // only the low KEY_BITS of the key take part
  localparam int KW = (KEY_BITS < chkt_pkg::KEY_W) ? KEY_BITS : chkt_pkg::KEY_W;
  localparam int EW = KW + HW;
  localparam int BW = $clog2(NUM_BUCKETS);
  localparam int RW = BUCKET_SLOTS * EW;

  // pipeline handshake
  logic in_acc;
  logic a_to_b;
  logic b_to_c;
  logic c_adv;

  // stage a: input register
  logic                          a_v_r;
  logic [chkt_pkg::OP_W-1:0]     a_op_r;
  logic [KW-1:0]                 a_key_r;
  logic [HW-1:0]                 a_hdl_r;

  // stage b: quotient registered, remainder and row read
  logic                          b_v_r;
  logic [chkt_pkg::OP_W-1:0]     b_op_r;
  logic [KW-1:0]                 b_key_r;
  logic [HW-1:0]                 b_hdl_r;
  logic [BW-1:0]                 bucket_b;

  // stage c: row compare and write back
  logic                          c_v_r;
  logic [chkt_pkg::OP_W-1:0]     c_op_r;
  logic [KW-1:0]                 c_key_r;
  logic [HW-1:0]                 c_hdl_r;
  logic [BW-1:0]                 c_bucket_r;
  logic                          fwd_hit_r;
  logic [BUCKET_SLOTS-1:0]       fwd_vld_r;
  logic [RW-1:0]                 fwd_ent_r;
  logic [BUCKET_SLOTS-1:0]       rd_vld;
  logic [RW-1:0]                 rd_ent;
  logic [BUCKET_SLOTS-1:0]       cur_vld;
  logic [RW-1:0]                 cur_ent;
  logic [BUCKET_SLOTS-1:0]       new_vld;
  logic [RW-1:0]                 new_ent;
  chkt_pkg::slot_res_t           res;

  // result register
  logic                          out_v_r;
  chkt_pkg::status_t             out_status_r;
  logic [HW-1:0]                 out_hdl_r;

  // clear pass
  logic                          clr_busy_r;
  logic [BW-1:0]                 clr_idx_r;

  // memory write port
  logic                          mem_vld_we;
  logic                          mem_ent_we;
  logic [BW-1:0]                 mem_waddr;
  logic [BUCKET_SLOTS-1:0]       mem_vld_wdata;

  assign c_adv     = c_v_r && (!out_v_r || out_tready);
  assign b_to_c    = b_v_r && (!c_v_r || c_adv);
  assign a_to_b    = a_v_r && (!b_v_r || b_to_c);
  assign in_tready = !clr_busy_r && (!a_v_r || a_to_b);
  assign in_acc    = in_tvalid && in_tready;

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else begin
      if (in_acc) begin
        a_v_r <= 1'b1;
      end else if (a_to_b) begin
        a_v_r <= 1'b0;
      end
      if (a_to_b) begin
        b_v_r <= 1'b1;
      end else if (b_to_c) begin
        b_v_r <= 1'b0;
      end
      if (b_to_c) begin
        c_v_r <= 1'b1;
      end else if (c_adv) begin
        c_v_r <= 1'b0;
      end
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_op_r  <= in_tuser;
      a_key_r <= in_tdata[KW-1:0];
      a_hdl_r <= in_tdata[31:16];
    end
    if (a_to_b) begin
      b_op_r  <= a_op_r;
      b_key_r <= a_key_r;
      b_hdl_r <= a_hdl_r;
    end
    if (b_to_c) begin
      c_op_r     <= b_op_r;
      c_key_r    <= b_key_r;
      c_hdl_r    <= b_hdl_r;
      c_bucket_r <= bucket_b;
    end
  end

  // the row read at this edge misses a write to the same row at this edge,
  // so keep what stage c writes and use it instead
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else if (b_to_c) begin
      fwd_hit_r <= c_adv && (c_bucket_r == bucket_b);
    end
  end

  always_ff @(posedge clk) begin
    if (b_to_c) begin
      fwd_vld_r <= new_vld;
      fwd_ent_r <= new_ent;
    end
  end

  chkt_hash #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .KW          (KW)
  ) u_hash (
    .clk      (clk),
    .load_i   (a_to_b),
    .key_a_i  (a_key_r),
    .key_b_i  (b_key_r),
    .bucket_o (bucket_b)
  );

  // clear pass owns the valid write port until it ends
  assign mem_vld_we    = clr_busy_r || (c_adv && res.vld_we);
  assign mem_ent_we    = !clr_busy_r && c_adv && res.ent_we;
  assign mem_waddr     = clr_busy_r ? clr_idx_r : c_bucket_r;
  assign mem_vld_wdata = clr_busy_r ? '0 : new_vld;

  chkt_bucket_mem #(
    .NUM_BUCKETS  (NUM_BUCKETS),
    .BUCKET_SLOTS (BUCKET_SLOTS),
    .EW           (EW)
  ) u_mem (
    .clk         (clk),
    .vld_we_i    (mem_vld_we),
    .ent_we_i    (mem_ent_we),
    .waddr_i     (mem_waddr),
    .vld_wdata_i (mem_vld_wdata),
    .ent_wdata_i (new_ent),
    .rd_en_i     (b_to_c),
    .raddr_i     (bucket_b),
    .rd_vld_o    (rd_vld),
    .rd_ent_o    (rd_ent)
  );

  assign cur_vld = fwd_hit_r ? fwd_vld_r : rd_vld;
  assign cur_ent = fwd_hit_r ? fwd_ent_r : rd_ent;

  chkt_slot_logic #(
    .BUCKET_SLOTS (BUCKET_SLOTS),
    .KW           (KW)
  ) u_slot (
    .op_i  (c_op_r),
    .key_i (c_key_r),
    .hdl_i (c_hdl_r),
    .vld_i (cur_vld),
    .ent_i (cur_ent),
    .vld_o (new_vld),
    .ent_o (new_ent),
    .res_o (res)
  );

  // result register, refilled in the cycle it is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (c_adv) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (c_adv) begin
      out_status_r <= res.status;
      out_hdl_r    <= res.found_handle;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = out_hdl_r;

  // clear pass after reset, one bucket a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clr_busy_r) begin
      if (clr_idx_r == BW'(NUM_BUCKETS - 1)) begin
        clr_busy_r <= 1'b0;
      end else begin
        clr_idx_r <= clr_idx_r + BW'(1);
      end
    end
  end

  `CHKT_NEVER(a_clear_no_row_op, clk, rst_n, clr_busy_r && (b_v_r || c_v_r),
              "row operation during clear pass")
  `CHKT_ASSERT(a_fwd_matches_row, clk, rst_n,
               (b_to_c && c_adv) |=> (fwd_hit_r == (c_bucket_r == $past(c_bucket_r))),
               "forward flag does not match back-to-back bucket")
  `CHKT_ASSERT(a_c_holds_on_stall, clk, rst_n,
               (c_v_r && !c_adv) |=> (c_v_r && $stable(c_key_r) && $stable(c_op_r)
                                      && $stable(c_bucket_r)),
               "stage c changed while stalled")

endmodule

// ===== rtl/chkt_hash.sv =====
// bucket index from key: reciprocal multiply, registered, then remainder
module chkt_hash #(
  parameter int NUM_BUCKETS = chkt_pkg::NUM_BUCKETS_DEF,
  parameter int KW          = chkt_pkg::KEY_W
) (
  input  logic                           clk,
  input  logic                           load_i,
  input  logic [KW-1:0]                  key_a_i,
  input  logic [KW-1:0]                  key_b_i,
  output logic [$clog2(NUM_BUCKETS)-1:0] bucket_o
);

  localparam int BW = $clog2(NUM_BUCKETS);
  localparam int SH = KW + BW;
  localparam int PW = SH + KW;
  localparam int RW = (KW > BW) ? KW : BW;
  localparam longint unsigned MULT =
    ((64'd1 << SH) + longint'(NUM_BUCKETS) - 64'd1) / longint'(NUM_BUCKETS);

  logic [PW-1:0] prod;
  logic [KW-1:0] q_nxt;
  logic [KW-1:0] q_r;
  logic [RW-1:0] rem;

  // exact floor(key / buckets) for every key of KW bits
  assign prod  = PW'(key_a_i) * PW'(MULT);
  assign q_nxt = prod[PW-1:SH];

  always_ff @(posedge clk) begin
    if (load_i) begin
      q_r <= q_nxt;
    end
  end

  assign rem      = RW'(key_b_i) - RW'(q_r) * RW'(NUM_BUCKETS);
  assign bucket_o = rem[BW-1:0];

endmodule

// ===== rtl/chkt_bucket_mem.sv =====
// bucket row storage: valid row and key/handle row, one read and one write port
module chkt_bucket_mem #(
  parameter int NUM_BUCKETS  = chkt_pkg::NUM_BUCKETS_DEF,
  parameter int BUCKET_SLOTS = chkt_pkg::BUCKET_SLOTS_DEF,
  parameter int EW           = chkt_pkg::KEY_W + chkt_pkg::HANDLE_W
) (
  input  logic                           clk,
  input  logic                           vld_we_i,
  input  logic                           ent_we_i,
  input  logic [$clog2(NUM_BUCKETS)-1:0] waddr_i,
  input  logic [BUCKET_SLOTS-1:0]        vld_wdata_i,
  input  logic [BUCKET_SLOTS*EW-1:0]     ent_wdata_i,
  input  logic                           rd_en_i,
  input  logic [$clog2(NUM_BUCKETS)-1:0] raddr_i,
  output logic [BUCKET_SLOTS-1:0]        rd_vld_o,
  output logic [BUCKET_SLOTS*EW-1:0]     rd_ent_o
);

  logic [BUCKET_SLOTS-1:0]    vld_mem [NUM_BUCKETS];
  logic [BUCKET_SLOTS*EW-1:0] ent_mem [NUM_BUCKETS];
  logic [BUCKET_SLOTS-1:0]    rd_vld_r;
  logic [BUCKET_SLOTS*EW-1:0] rd_ent_r;

  always_ff @(posedge clk) begin
    if (vld_we_i) begin
      vld_mem[waddr_i] <= vld_wdata_i;
    end
    if (ent_we_i) begin
      ent_mem[waddr_i] <= ent_wdata_i;
    end
  end

  // read returns the old row on a same-address write
  always_ff @(posedge clk) begin
    if (rd_en_i) begin
      rd_vld_r <= vld_mem[raddr_i];
      rd_ent_r <= ent_mem[raddr_i];
    end
  end

  assign rd_vld_o = rd_vld_r;
  assign rd_ent_o = rd_ent_r;

endmodule

// ===== rtl/chkt_slot_logic.sv =====
// side-by-side slot compare of one bucket row and the updated row
module chkt_slot_logic #(
  parameter int BUCKET_SLOTS = chkt_pkg::BUCKET_SLOTS_DEF,
  parameter int KW           = chkt_pkg::KEY_W
) (
  input  logic [chkt_pkg::OP_W-1:0]                      op_i,
  input  logic [KW-1:0]                                  key_i,
  input  logic [chkt_pkg::HANDLE_W-1:0]                  hdl_i,
  input  logic [BUCKET_SLOTS-1:0]                        vld_i,
  input  logic [BUCKET_SLOTS*(KW+chkt_pkg::HANDLE_W)-1:0] ent_i,
  output logic [BUCKET_SLOTS-1:0]                        vld_o,
  output logic [BUCKET_SLOTS*(KW+chkt_pkg::HANDLE_W)-1:0] ent_o,
  output chkt_pkg::slot_res_t                            res_o
);

  localparam int HW = chkt_pkg::HANDLE_W;
  localparam int EW = KW + HW;

  logic [BUCKET_SLOTS-1:0] hit;
  logic [BUCKET_SLOTS-1:0] hit_1h;
  logic [BUCKET_SLOTS-1:0] free;
  logic [BUCKET_SLOTS-1:0] free_1h;
  logic [HW-1:0]           hit_hdl;
  logic                    any_hit;
  logic                    any_free;

  always_comb begin
    hit_hdl = '0;
    for (int s = 0; s < BUCKET_SLOTS; s++) begin
      hit[s] = vld_i[s] && (ent_i[s*EW +: KW] == key_i);
    end
    // lowest matching slot and lowest free slot
    hit_1h   = hit & (~hit + BUCKET_SLOTS'(1));
    free     = ~vld_i;
    free_1h  = free & (~free + BUCKET_SLOTS'(1));
    any_hit  = |hit;
    any_free = |free;
    for (int s = 0; s < BUCKET_SLOTS; s++) begin
      if (hit_1h[s]) begin
        hit_hdl = hit_hdl | ent_i[s*EW+KW +: HW];
      end
    end
  end

  always_comb begin
    vld_o              = vld_i;
    ent_o              = ent_i;
    res_o.status       = chkt_pkg::ST_NOT_FOUND;
    res_o.found_handle = '0;
    res_o.vld_we       = 1'b0;
    res_o.ent_we       = 1'b0;
    case (op_i)
      chkt_pkg::OP_LOOKUP: begin
        if (any_hit) begin
          res_o.status       = chkt_pkg::ST_OK;
          res_o.found_handle = hit_hdl;
        end
      end
      chkt_pkg::OP_INSERT: begin
        if (any_hit) begin
          res_o.status = chkt_pkg::ST_DUPLICATE;
        end else if (!any_free) begin
          res_o.status = chkt_pkg::ST_FULL;
        end else begin
          res_o.status = chkt_pkg::ST_OK;
          res_o.vld_we = 1'b1;
          res_o.ent_we = 1'b1;
          vld_o        = vld_i | free_1h;
          for (int s = 0; s < BUCKET_SLOTS; s++) begin
            if (free_1h[s]) begin
              ent_o[s*EW +: EW] = {hdl_i, key_i};
            end
          end
        end
      end
      chkt_pkg::OP_REMOVE: begin
        if (any_hit) begin
          res_o.status = chkt_pkg::ST_OK;
          res_o.vld_we = 1'b1;
          vld_o        = vld_i & ~hit_1h;
        end
      end
      default: begin
        res_o.status = chkt_pkg::ST_NOT_FOUND;
      end
    endcase
  end

endmodule
